// ----- src/psched_pkg.sv -----
// Shared types and constants for the priority scheduler core.
package psched_pkg;

    localparam int ID_W   = 8;
    localparam int TICK_W = 16;
    localparam int PRIO_W = 8;
    localparam int TIME_W = 21;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic [ID_W-1:0]   job_id;
        logic [TICK_W-1:0] arrival;
        logic [TICK_W-1:0] burst;
        logic [PRIO_W-1:0] prio_level;
        logic              last_job;
    } job_in_t;

    typedef struct packed {
        logic [ID_W-1:0]   out_job_id;
        logic [TIME_W-1:0] completion;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] turnaround;
        logic              last_result;
    } result_t;

    // One stored job as held in a cell.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] arrival;
        logic [TICK_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
    } job_t;

    // Best job seen so far as it walks down the chain.
    typedef struct packed {
        logic found;
        job_t job;
    } cand_t;

    // Broadcast controls from the sequencer to every cell.
    typedef struct packed {
        logic load_en;
        logic take_en;
        logic clear_taken;
    } cell_ctl_t;

endpackage

// ----- src/priority_nonpreemptive_scheduler_core.sv -----
// Nonpreemptive priority scheduler: job store as a chain of cells plus the timing sequencer.
// Jobs load at one per cycle into a row of MAX_JOBS cells. The item marked last_job, or the
// item that fills the row, closes the batch; no job is taken while its results are produced.
// For each result, a best-so-far candidate walks the cell chain one cell per cycle (ties to
// earlier arrival, then lower load order); then completion, turnaround and waiting time are
// computed in that order. Completion time saturates at 2097151. The last result may wait in
// the output register while the next batch loads.
module priority_nonpreemptive_scheduler_core #(
    parameter int MAX_JOBS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_stall,
    input  psched_pkg::job_in_t job_data,
    output logic                res_valid,
    input  logic                res_stall,
    output psched_pkg::result_t res_data
);
    import psched_pkg::*;

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_CALC_DONE,
        ST_CALC_TURN,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  scan_cnt_reg;
    logic [CNT_W-1:0]  produced_reg;
    logic [TIME_W-1:0] clock_reg;
    logic              res_valid_reg;
    result_t           res_data_reg;

    job_t              sel_job_reg;
    logic [TIME_W-1:0] done_reg;
    logic [TIME_W-1:0] turn_reg;

    cand_t             chain [MAX_JOBS+1];
    logic [IDX_W-1:0]  chain_idx [MAX_JOBS+1];
    cell_ctl_t         ctl;
    job_t              load_job;

    logic              job_fire;
    logic              scan_end;
    logic              out_free;
    logic              emit_fire;
    logic              batch_end;
    logic              last_out;
    logic [CNT_W-1:0]  count_inc;
    logic [TIME_W-1:0] arr_ext;
    logic [TIME_W-1:0] burst_ext;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W:0]   done_sum;
    logic [TIME_W-1:0] wait_time;

    assign job_stall = (state_reg != ST_LOAD);
    assign job_fire  = job_valid && !job_stall;
    assign count_inc = count_reg + CNT_W'(1);
    assign batch_end = job_data.last_job || (count_inc == CNT_W'(MAX_JOBS));

    assign scan_end  = (state_reg == ST_SCAN) && (scan_cnt_reg == CNT_W'(MAX_JOBS));
    assign out_free  = !res_valid_reg || !res_stall;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;
    assign last_out  = ((produced_reg + CNT_W'(1)) == count_reg);

    assign load_job.id      = job_data.job_id;
    assign load_job.arrival = job_data.arrival;
    assign load_job.burst   = job_data.burst;
    assign load_job.prio    = job_data.prio_level;

    assign ctl.load_en     = job_fire;
    assign ctl.take_en     = scan_end;
    assign ctl.clear_taken = emit_fire && last_out;

    assign chain[0]     = '0;
    assign chain_idx[0] = '0;

    for (genvar k = 0; k < MAX_JOBS; k++)
    begin : g_cell
        psched_cell #(
            .IDX   (k),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .load_slot    (count_reg[IDX_W-1:0]),
            .load_job     (load_job),
            .count        (count_reg),
            .take_idx     (chain_idx[MAX_JOBS]),
            .cand_in      (chain[k]),
            .cand_idx_in  (chain_idx[k]),
            .cand_out     (chain[k+1]),
            .cand_idx_out (chain_idx[k+1])
        );
    end

    // Timing arithmetic for the selected job.
    assign arr_ext    = TIME_W'(sel_job_reg.arrival);
    assign burst_ext  = TIME_W'(sel_job_reg.burst);
    assign start_time = (arr_ext > clock_reg) ? arr_ext : clock_reg;
    assign done_sum   = {1'b0, start_time} + {1'b0, burst_ext};
    assign wait_time  = (turn_reg >= burst_ext) ? (turn_reg - burst_ext) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            produced_reg  <= '0;
            clock_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_LOAD:
                begin
                    if (job_fire)
                    begin
                        count_reg <= count_inc;
                        if (batch_end)
                        begin
                            state_reg    <= ST_SCAN;
                            scan_cnt_reg <= '0;
                            produced_reg <= '0;
                            clock_reg    <= '0;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (scan_end)
                    begin
                        state_reg <= ST_CALC_DONE;
                    end
                    else
                    begin
                        scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                    end
                end
                ST_CALC_DONE:
                begin
                    state_reg <= ST_CALC_TURN;
                end
                ST_CALC_TURN:
                begin
                    // advance the schedule clock to this job's completion
                    clock_reg <= done_reg;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        produced_reg  <= produced_reg + CNT_W'(1);
                        if (last_out)
                        begin
                            state_reg <= ST_LOAD;
                            count_reg <= '0;
                            clock_reg <= '0;
                        end
                        else
                        begin
                            state_reg    <= ST_SCAN;
                            scan_cnt_reg <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (scan_end)
        begin
            sel_job_reg <= chain[MAX_JOBS].job;
        end
        if (state_reg == ST_CALC_DONE)
        begin
            // Saturate completion on overflow of the time range.
            done_reg <= done_sum[TIME_W] ? TIME_MAX : done_sum[TIME_W-1:0];
        end
        if (state_reg == ST_CALC_TURN)
        begin
            turn_reg <= (done_reg >= arr_ext) ? (done_reg - arr_ext) : '0;
        end
        if (emit_fire)
        begin
            res_data_reg.out_job_id  <= sel_job_reg.id;
            res_data_reg.completion  <= done_reg;
            res_data_reg.waiting     <= wait_time;
            res_data_reg.turnaround  <= turn_reg;
            res_data_reg.last_result <= last_out;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ----- src/psched_cell.sv -----
// One scheduler cell: holds a job, its taken bit, and one stage of the selection chain.
module psched_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psched_pkg::cell_ctl_t ctl,
    input  logic [IDX_W-1:0]      load_slot,
    input  psched_pkg::job_t      load_job,
    input  logic [CNT_W-1:0]      count,
    input  logic [IDX_W-1:0]      take_idx,
    input  psched_pkg::cand_t     cand_in,
    input  logic [IDX_W-1:0]      cand_idx_in,
    output psched_pkg::cand_t     cand_out,
    output logic [IDX_W-1:0]      cand_idx_out
);
    import psched_pkg::*;

    job_t             job_reg;
    logic             taken_reg;
    logic             found_reg;
    job_t             cand_job_reg;
    logic [IDX_W-1:0] cand_idx_reg;

    logic active;
    logic better;

    assign active = (CNT_W'(IDX) < count) && !taken_reg;

    // Strict compares keep the earlier cell on a full tie.
    assign better = active &&
                    (!cand_in.found ||
                     (job_reg.prio > cand_in.job.prio) ||
                     ((job_reg.prio == cand_in.job.prio) &&
                      (job_reg.arrival < cand_in.job.arrival)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= better ? 1'b1 : cand_in.found;
            if (ctl.clear_taken)
            begin
                taken_reg <= 1'b0;
            end
            else if (ctl.take_en && (take_idx == IDX_W'(IDX)))
            begin
                taken_reg <= 1'b1;
            end
            else if (ctl.load_en && (load_slot == IDX_W'(IDX)))
            begin
                taken_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_en && (load_slot == IDX_W'(IDX)))
        begin
            job_reg <= load_job;
        end
        cand_job_reg <= better ? job_reg : cand_in.job;
        cand_idx_reg <= better ? IDX_W'(IDX) : cand_idx_in;
    end

    assign cand_out.found = found_reg;
    assign cand_out.job   = cand_job_reg;
    assign cand_idx_out   = cand_idx_reg;

endmodule
